[sv/obe_pkg.sv]
// Shared types, constants and slot packing for the octagon bound table.
// Used by the channel interfaces, the term decoder and the top level.
package obe_pkg;

  localparam int NumVars    = 16;
  localparam int TableDepth = 512;
  localparam int BoundW     = 32;

  localparam int VAR_W  = $clog2(NumVars);
  localparam int VAR2_W = VAR_W + 1;
  localparam int SLOT_W = $clog2(TableDepth);
  localparam int PACK_W = 2 * VAR_W + 3;

  // Operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_COMBINE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_TIGHT   = 2'd0;
  localparam logic [1:0] ST_CANCEL  = 2'd1;
  localparam logic [1:0] ST_NOSHARE = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic              sign_a_first;
    logic [VAR_W-1:0]  var_a_first;
    logic              sign_a_second;
    logic [VAR2_W-1:0] var_a_second;
    logic              sign_b_first;
    logic [VAR_W-1:0]  var_b_first;
    logic              sign_b_second;
    logic [VAR2_W-1:0] var_b_second;
    logic [VAR_W-1:0]  elim_var;
    logic [SLOT_W-1:0] slot_index;
    logic [BoundW-1:0] bound_in;
  } item_t;

  // One kept term of a constraint after elimination
  typedef struct packed {
    logic             sign;
    logic             valid;
    logic [VAR_W-1:0] idx;
  } term_t;

  // Decoded combine control, decoder to sequencer
  typedef struct packed {
    logic              no_result;
    logic              cancel;
    logic              halve;
    logic [SLOT_W-1:0] slot_a;
    logic [SLOT_W-1:0] slot_b;
    logic [SLOT_W-1:0] tgt;
  } dec_t;

  // Pack a term "s1 x_n1 [s2 x_n2]" into a table slot
  function automatic logic [SLOT_W-1:0] slot_of(logic s1, logic [VAR_W-1:0] n1,
                                                logic s2, logic v2,
                                                logic [VAR_W-1:0] n2);
    logic [PACK_W-1:0] p;
    p = PACK_W'(PACK_W'(n1) * PACK_W'(n1)) << 1;
    if (!s1) begin
      p = p + PACK_W'({n1, 1'b1});
    end
    if (v2) begin
      p = p + PACK_W'({n2, 1'b0}) + (s2 ? PACK_W'(1) : PACK_W'(2));
    end
    return p[SLOT_W-1:0];
  endfunction

endpackage

[sv/obe_if.sv]
// Valid/ready channel interfaces for the item and result beats.
// Depends on obe_pkg for field widths.
interface obe_in_if import obe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic              sign_a_first;
  logic [VAR_W-1:0]  var_a_first;
  logic              sign_a_second;
  logic signed [VAR2_W-1:0] var_a_second;
  logic              sign_b_first;
  logic [VAR_W-1:0]  var_b_first;
  logic              sign_b_second;
  logic signed [VAR2_W-1:0] var_b_second;
  logic [VAR_W-1:0]  elim_var;
  logic [SLOT_W-1:0] slot_index;
  logic signed [BoundW-1:0] bound_in;

  modport source (output valid, op, sign_a_first, var_a_first, sign_a_second,
                  var_a_second, sign_b_first, var_b_first, sign_b_second,
                  var_b_second, elim_var, slot_index, bound_in, input ready);
  modport sink (input valid, op, sign_a_first, var_a_first, sign_a_second,
                var_a_second, sign_b_first, var_b_first, sign_b_second,
                var_b_second, elim_var, slot_index, bound_in, output ready);
endinterface

interface obe_out_if import obe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] target_slot;
  logic signed [BoundW-1:0] new_bound;
  logic signed [BoundW-1:0] read_bound;

  modport source (output valid, status, target_slot, new_bound, read_bound,
                  input ready);
  modport sink (input valid, status, target_slot, new_bound, read_bound,
                output ready);
endinterface

[sv/obe_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module obe_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write or read one entry; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/obe_decode.sv]
// Combine decoder: finds the eliminated variable, keeps the other terms,
// and packs the source and target slots. Depends on obe_pkg.
module obe_decode import obe_pkg::*; (
  input  item_t item_i,
  output dec_t  dec_o
);

  term_t a1, a2, b1, b2, ka, kb;
  logic  a1_hit, a2_hit, b1_hit, b2_hit, found, same, a_first;

  // Unpack the four terms; a negative second index means none
  always_comb begin
    a1 = '{sign: item_i.sign_a_first, valid: 1'b1, idx: item_i.var_a_first};
    a2 = '{sign: item_i.sign_a_second, valid: ~item_i.var_a_second[VAR2_W-1],
           idx: item_i.var_a_second[VAR_W-1:0]};
    b1 = '{sign: item_i.sign_b_first, valid: 1'b1, idx: item_i.var_b_first};
    b2 = '{sign: item_i.sign_b_second, valid: ~item_i.var_b_second[VAR2_W-1],
           idx: item_i.var_b_second[VAR_W-1:0]};
    a1_hit = a1.idx == item_i.elim_var;
    a2_hit = a2.valid && (a2.idx == item_i.elim_var);
    b1_hit = b1.idx == item_i.elim_var;
    b2_hit = b2.valid && (b2.idx == item_i.elim_var);
  end

  // Pick the first matching pair and keep the other term of each
  always_comb begin
    found = 1'b1;
    ka    = a2;
    kb    = b2;
    priority if (a1_hit && b1_hit) begin
      ka = a2; kb = b2;
    end else if (a1_hit && b2_hit) begin
      ka = a2; kb = b1;
    end else if (a2_hit && b1_hit) begin
      ka = a1; kb = b2;
    end else if (a2_hit && b2_hit) begin
      ka = a1; kb = b1;
    end else begin
      found = 1'b0;
    end
  end

  // Classify the kept pair and pack the slots
  always_comb begin
    same    = ka.valid && kb.valid && (ka.idx == kb.idx);
    a_first = ka.valid && (!kb.valid || (ka.idx > kb.idx));
    dec_o.no_result = !found || (!ka.valid && !kb.valid);
    dec_o.cancel    = same && (ka.sign != kb.sign);
    dec_o.halve     = same;
    dec_o.slot_a    = slot_of(a1.sign, a1.idx, a2.sign, a2.valid, a2.idx);
    dec_o.slot_b    = slot_of(b1.sign, b1.idx, b2.sign, b2.valid, b2.idx);
    if (same) begin
      dec_o.tgt = slot_of(ka.sign, ka.idx, 1'b0, 1'b0, kb.idx);
    end else if (a_first) begin
      dec_o.tgt = slot_of(ka.sign, ka.idx, kb.sign, kb.valid, kb.idx);
    end else begin
      dec_o.tgt = slot_of(kb.sign, kb.idx, ka.sign, ka.valid, ka.idx);
    end
  end

endmodule

[sv/octagon_bound_elimination.sv]
// Octagon bound table with variable elimination, single-port table RAM.
// A write or read uses the table port in the issue state, then emits its beat.
// A combine reads both source slots, then the target slot, and writes back the
// smaller bound; a cancelling pair stops after the source reads, and nothing
// shared skips the table. One item at a time: input is taken only in idle.
// Reset clears the sequencer and output valid; table contents stay undefined.
module octagon_bound_elimination import obe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  obe_in_if.sink    in_i,
  obe_out_if.source out_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_RDB   = 6'b000100,
    S_RDT   = 6'b001000,
    S_MIN   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  item_t  item_q;
  dec_t   dec;

  logic [BoundW-1:0] ba_q, cand_q, cand, rdata, wdata, nv;
  logic [SLOT_W-1:0] addr;
  logic              we, re, in_acc, load_out;
  logic [BoundW:0]   sum, half_adj;

  logic [1:0]        res_status_q;
  logic [SLOT_W-1:0] res_tgt_q;
  logic [BoundW-1:0] res_new_q;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [SLOT_W-1:0] out_tgt_q;
  logic [BoundW-1:0] out_new_q, out_read_q;

  assign in_i.ready = state_q == S_IDLE;
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_out   = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // Hold the accepted item beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= '{op: in_i.op, sign_a_first: in_i.sign_a_first,
                  var_a_first: in_i.var_a_first, sign_a_second: in_i.sign_a_second,
                  var_a_second: in_i.var_a_second, sign_b_first: in_i.sign_b_first,
                  var_b_first: in_i.var_b_first, sign_b_second: in_i.sign_b_second,
                  var_b_second: in_i.var_b_second, elim_var: in_i.elim_var,
                  slot_index: in_i.slot_index, bound_in: in_i.bound_in};
    end
  end

  obe_decode u_decode (
    .item_i (item_q),
    .dec_o  (dec)
  );

  obe_ram #(
    .Width (BoundW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .re_i    (re),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Candidate bound: halved sum truncated toward zero, or saturated sum
  always_comb begin
    sum      = {ba_q[BoundW-1], ba_q} + {rdata[BoundW-1], rdata};
    half_adj = sum + {{BoundW{1'b0}}, sum[BoundW] & sum[0]};
    if (dec.halve) begin
      cand = half_adj[BoundW:1];
    end else if (sum[BoundW] != sum[BoundW-1]) begin
      cand = sum[BoundW] ? {1'b1, {(BoundW-1){1'b0}}} : {1'b0, {(BoundW-1){1'b1}}};
    end else begin
      cand = sum[BoundW-1:0];
    end
  end

  // Keep the smaller of the stored target bound and the candidate
  assign nv = ($signed(rdata) < $signed(cand_q)) ? rdata : cand_q;

  // Sequencer: drive the table port and advance
  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    re      = 1'b0;
    addr    = item_q.slot_index;
    wdata   = item_q.bound_in;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        unique case (item_q.op)
          OP_WRITE: begin
            we      = 1'b1;
            state_d = S_EMIT;
          end
          OP_READ: begin
            re      = 1'b1;
            state_d = S_EMIT;
          end
          OP_COMBINE: begin
            if (dec.no_result) begin
              state_d = S_EMIT;
            end else begin
              re      = 1'b1;
              addr    = dec.slot_a;
              state_d = S_RDB;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RDB: begin
        re      = 1'b1;
        addr    = dec.slot_b;
        state_d = S_RDT;
      end
      S_RDT: begin
        if (dec.cancel) begin
          state_d = S_EMIT;
        end else begin
          re      = 1'b1;
          addr    = dec.tgt;
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        we      = 1'b1;
        addr    = dec.tgt;
        wdata   = nv;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Gather operands and the result fields
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_ISSUE: begin
        res_tgt_q    <= '0;
        res_new_q    <= '0;
        res_status_q <= (item_q.op == OP_COMBINE) ? ST_NOSHARE : ST_DONE;
      end
      S_RDB: ba_q <= rdata;
      S_RDT: begin
        cand_q <= cand;
        if (dec.cancel) begin
          res_status_q <= ST_CANCEL;
        end
      end
      S_MIN: begin
        res_status_q <= ST_TIGHT;
        res_tgt_q    <= dec.tgt;
        res_new_q    <= nv;
      end
      default: ;
    endcase
  end

  // Output register: load a result beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= res_status_q;
      out_tgt_q    <= res_tgt_q;
      out_new_q    <= res_new_q;
      out_read_q   <= (item_q.op == OP_READ) ? rdata : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.target_slot = out_tgt_q;
  assign out_o.new_bound   = out_new_q;
  assign out_o.read_bound  = out_read_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the octagon bound table with variable elimination.
// Depends on obe_pkg, the obe_in_if / obe_out_if channels and the top level.
module tb;
  import obe_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam bit PLUS  = 1'b0;
  localparam bit MINUS = 1'b1;
  localparam int NONE  = -1;

  localparam int RunLimit    = 400000;
  localparam int DrainCycles = 12;
  localparam int MaxReports  = 10;
  localparam int RandomItems = 210;
  localparam logic signed [BoundW-1:0] BoundMax = 32'sh7fffffff;
  localparam logic signed [BoundW-1:0] BoundMin = 32'sh80000000;

  typedef struct packed {
    logic [1:0]               status;
    logic [SLOT_W-1:0]        target_slot;
    logic signed [BoundW-1:0] new_bound;
    logic signed [BoundW-1:0] read_bound;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  obe_in_if  in_if ();
  obe_out_if out_if ();

  octagon_bound_elimination uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the bound table and the outcomes still owed by the block
  logic signed [BoundW-1:0] bound_mem [TableDepth];
  outcome_t pending_outcomes [$];

  int cycle_cnt = 0;
  int error_cnt = 0;
  bit no_idle   = 1'b0;
  int n_write = 0, n_read = 0, n_unused = 0;
  int n_tight = 0, n_cancel = 0, n_noshare = 0;

  // Clock
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Abort a hung run
  initial begin : watchdog
    wait (cycle_cnt >= RunLimit);
    $display("FAILED: results differ");
    $finish;
  end

  // Pack a term "s1 x_n1 [s2 x_n2]" into its table slot
  function automatic int pack_slot(bit s1, int n1, bit s2, int n2);
    int p;
    p = 2 * n1 * n1;
    if (!s1) begin
      p += 2 * n1 + 1;
    end
    if (n2 >= 0) begin
      p += 2 * n2 + (s2 ? 1 : 2);
    end
    return p % TableDepth;
  endfunction

  // Any negative second index stands for no second variable
  function automatic int second_index(logic [VAR2_W-1:0] raw);
    if (raw[VAR2_W-1]) begin
      return NONE;
    end
    return int'(raw);
  endfunction

  // Apply one accepted item to the shadow table; return 1 if a beat is owed
  function automatic bit apply_bound_op(input item_t it, output outcome_t res);
    int na1, na2, nb1, nb2, e, na, nb, tgt;
    bit sa, sb;
    longint ba, bb, nv;
    res = '0;
    res.status = ST_DONE;
    case (it.op)
      OP_WRITE: begin
        bound_mem[it.slot_index] = it.bound_in;
        n_write++;
        return 1'b1;
      end
      OP_READ: begin
        res.read_bound = bound_mem[it.slot_index];
        n_read++;
        return 1'b1;
      end
      OP_COMBINE: begin
      end
      default: begin
        n_unused++;
        return 1'b0;
      end
    endcase

    na1 = int'(it.var_a_first);
    nb1 = int'(it.var_b_first);
    na2 = second_index(it.var_a_second);
    nb2 = second_index(it.var_b_second);
    e   = int'(it.elim_var);

    // First matching position of the eliminated variable wins
    if (na1 == e && nb1 == e) begin
      sa = it.sign_a_second; na = na2; sb = it.sign_b_second; nb = nb2;
    end else if (na1 == e && nb2 == e) begin
      sa = it.sign_a_second; na = na2; sb = it.sign_b_first; nb = nb1;
    end else if (na2 == e && nb1 == e) begin
      sa = it.sign_a_first; na = na1; sb = it.sign_b_second; nb = nb2;
    end else if (na2 == e && nb2 == e) begin
      sa = it.sign_a_first; na = na1; sb = it.sign_b_first; nb = nb1;
    end else begin
      res.status = ST_NOSHARE;
      n_noshare++;
      return 1'b1;
    end
    if (na < 0 && nb < 0) begin
      res.status = ST_NOSHARE;
      n_noshare++;
      return 1'b1;
    end

    ba = bound_mem[pack_slot(it.sign_a_first, na1, it.sign_a_second, na2)];
    bb = bound_mem[pack_slot(it.sign_b_first, nb1, it.sign_b_second, nb2)];
    if (na == nb) begin
      if (sa != sb) begin
        res.status = ST_CANCEL;
        n_cancel++;
        return 1'b1;
      end
      // Same variable twice: halve the sum, truncating toward zero
      tgt = pack_slot(sa, na, PLUS, NONE);
      nv  = (ba + bb) / 2;
    end else begin
      tgt = (na > nb) ? pack_slot(sa, na, sb, nb) : pack_slot(sb, nb, sa, na);
      nv  = ba + bb;
      if (nv > BoundMax) begin
        nv = BoundMax;
      end else if (nv < BoundMin) begin
        nv = BoundMin;
      end
    end
    // Keep the tighter of the old and the derived bound
    if (bound_mem[tgt] < nv) begin
      nv = bound_mem[tgt];
    end
    bound_mem[tgt]  = nv[BoundW-1:0];
    res.status      = ST_TIGHT;
    res.target_slot = tgt[SLOT_W-1:0];
    res.new_bound   = nv[BoundW-1:0];
    n_tight++;
    return 1'b1;
  endfunction

  // Put one item on the input channel
  task automatic drive_payload(input item_t it);
    in_if.op            <= it.op;
    in_if.sign_a_first  <= it.sign_a_first;
    in_if.var_a_first   <= it.var_a_first;
    in_if.sign_a_second <= it.sign_a_second;
    in_if.var_a_second  <= it.var_a_second;
    in_if.sign_b_first  <= it.sign_b_first;
    in_if.var_b_first   <= it.var_b_first;
    in_if.sign_b_second <= it.sign_b_second;
    in_if.var_b_second  <= it.var_b_second;
    in_if.elim_var      <= it.elim_var;
    in_if.slot_index    <= it.slot_index;
    in_if.bound_in      <= it.bound_in;
  endtask

  // Send one beat after a random gap, then record what it should produce
  task automatic send_item(input item_t it);
    int gap;
    outcome_t res;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    drive_payload(it);
    do @(posedge clk_i); while (!in_if.ready);
    if (apply_bound_op(it, res)) begin
      pending_outcomes = {pending_outcomes, res};
    end
  endtask

  function automatic item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  // Bias bounds toward the extremes and small values
  function automatic logic [BoundW-1:0] random_bound();
    case ($urandom_range(0, 7))
      0:       return BoundMax;
      1:       return BoundMin;
      2:       return $urandom_range(0, 40) - 20;
      3:       return BoundMax - $urandom_range(0, 8);
      4:       return BoundMin + $urandom_range(0, 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_write(input int slot, input logic [BoundW-1:0] value);
    item_t it;
    it = random_item();
    it.op         = OP_WRITE;
    it.slot_index = SLOT_W'(slot);
    it.bound_in   = value;
    send_item(it);
  endtask

  task automatic send_read(input int slot);
    item_t it;
    it = random_item();
    it.op         = OP_READ;
    it.slot_index = SLOT_W'(slot);
    send_item(it);
  endtask

  task automatic send_combine(input bit sa1, input int na1, input bit sa2, input int na2,
                              input bit sb1, input int nb1, input bit sb2, input int nb2,
                              input int e);
    item_t it;
    it = random_item();
    it.op            = OP_COMBINE;
    it.sign_a_first  = sa1;
    it.var_a_first   = VAR_W'(na1);
    it.sign_a_second = sa2;
    it.var_a_second  = VAR2_W'(na2);
    it.sign_b_first  = sb1;
    it.var_b_first   = VAR_W'(nb1);
    it.sign_b_second = sb2;
    it.var_b_second  = VAR2_W'(nb2);
    it.elim_var      = VAR_W'(e);
    send_item(it);
  endtask

  // Kept variable of a constraint: mostly a real index, sometimes none
  function automatic int pick_kept();
    if ($urandom_range(0, 7) == 0) begin
      return NONE;
    end
    return $urandom_range(0, NumVars - 1);
  endfunction

  // Combine whose two constraints share the eliminated variable
  function automatic item_t combine_item();
    item_t it;
    int e, ka, kb;
    it = random_item();
    it.op = OP_COMBINE;
    e  = $urandom_range(0, NumVars - 1);
    ka = pick_kept();
    kb = ($urandom_range(0, 2) == 0) ? ka : pick_kept();
    it.elim_var = VAR_W'(e);
    if (ka < 0 || $urandom_range(0, 1)) begin
      it.var_a_first  = VAR_W'(e);
      it.var_a_second = (ka < 0) ? VAR2_W'($urandom_range(16, 31)) : VAR2_W'(ka);
    end else begin
      it.var_a_first  = VAR_W'(ka);
      it.var_a_second = VAR2_W'(e);
    end
    if (kb < 0 || $urandom_range(0, 1)) begin
      it.var_b_first  = VAR_W'(e);
      it.var_b_second = (kb < 0) ? VAR2_W'($urandom_range(16, 31)) : VAR2_W'(kb);
    end else begin
      it.var_b_first  = VAR_W'(kb);
      it.var_b_second = VAR2_W'(e);
    end
    return it;
  endfunction

  // Write every slot so that no later read meets an unwritten entry
  task automatic test_preload_table();
    for (int s = 0; s < TableDepth; s++) begin
      no_idle = (s < TableDepth / 2);
      send_write(s, random_bound());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_directed_cases();
    int sat_tgt;
    // Extreme bounds at the extreme slots
    send_write(0, BoundMax);
    send_write(TableDepth - 1, BoundMin);
    send_read(0);
    send_read(TableDepth - 1);

    // Pair result saturating high: +x3 -x5 with +x5 +x7 on x5
    sat_tgt = pack_slot(PLUS, 7, PLUS, 3);
    send_write(pack_slot(PLUS, 3, MINUS, 5), BoundMax);
    send_write(pack_slot(PLUS, 5, PLUS, 7), BoundMax);
    send_write(sat_tgt, BoundMax);
    send_combine(PLUS, 3, MINUS, 5, PLUS, 5, PLUS, 7, 5);
    send_read(sat_tgt);

    // Same terms saturating low
    send_write(pack_slot(PLUS, 3, MINUS, 5), BoundMin);
    send_write(pack_slot(PLUS, 5, PLUS, 7), BoundMin);
    send_combine(PLUS, 3, MINUS, 5, PLUS, 5, PLUS, 7, 5);

    // Equal kept terms: halved sum truncated toward zero
    send_write(pack_slot(PLUS, 2, PLUS, 4), -7);
    send_write(pack_slot(MINUS, 4, PLUS, 2), 4);
    send_write(pack_slot(PLUS, 2, PLUS, NONE), BoundMax);
    send_combine(PLUS, 2, PLUS, 4, MINUS, 4, PLUS, 2, 4);

    // Cancelling pair
    send_combine(PLUS, 2, PLUS, 4, MINUS, 4, MINUS, 2, 4);
    // Eliminated variable in neither constraint
    send_combine(PLUS, 1, PLUS, 2, PLUS, 3, PLUS, 4, 9);
    // Both kept terms empty
    send_combine(PLUS, 6, PLUS, NONE, MINUS, 6, MINUS, NONE, 6);
    // Most negative second index still means none
    send_combine(PLUS, 6, PLUS, -16, PLUS, 6, PLUS, 8, 6);
    // Unnormalised source term whose slot wraps past the table end
    send_combine(PLUS, 15, PLUS, 15, MINUS, 15, PLUS, 0, 15);

    // Unused op: no beat owed
    begin
      item_t it;
      it = random_item();
      it.op = OP_UNUSED;
      send_item(it);
    end
  endtask

  // Mostly well-formed combines, with reads, writes and noise mixed in
  task automatic test_random_mix();
    item_t it;
    int r;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 50 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_write($urandom_range(0, TableDepth - 1), random_bound());
      end else if (r < 27) begin
        send_read($urandom_range(0, TableDepth - 1));
      end else if (r < 90) begin
        send_item(combine_item());
      end else if (r < 97) begin
        it = random_item();
        it.op = OP_COMBINE;
        send_item(it);
      end else begin
        it = random_item();
        it.op = OP_UNUSED;
        send_item(it);
      end
    end
    no_idle = 1'b0;
  endtask

  // Check each result beat against the oldest owed outcome; stall at random
  initial begin : result_checker
    int stall;
    outcome_t want;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (pending_outcomes.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MaxReports) begin
            $display("cycle %0d: result beat with nothing owed (status %0d)",
                     cycle_cnt, out_if.status);
          end
        end else begin
          want = pending_outcomes.pop_front();
          if (out_if.status !== want.status || out_if.target_slot !== want.target_slot ||
              out_if.new_bound !== want.new_bound ||
              out_if.read_bound !== want.read_bound) begin
            error_cnt++;
            if (error_cnt <= MaxReports) begin
              $display("cycle %0d: expected status %0d slot %0d new %0d read %0d",
                       cycle_cnt, want.status, want.target_slot, want.new_bound,
                       want.read_bound);
              $display("          got      status %0d slot %0d new %0d read %0d",
                       out_if.status, out_if.target_slot, out_if.new_bound,
                       out_if.read_bound);
            end
          end
        end
        stall = no_idle ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          out_if.ready <= 1'b0;
        end
      end else if (!out_if.ready) begin
        if (stall > 0) begin
          stall--;
        end
        if (stall == 0) begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    drive_payload('0);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_preload_table();
    test_directed_cases();
    test_random_mix();
    in_if.valid <= 1'b0;

    // Drain owed results, then watch for stray beats
    wait (pending_outcomes.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d writes, %0d reads and %0d unused-op items.",
             n_write, n_read, n_unused);
    $display("Combines: %0d tightened, %0d cancelling, %0d with no result.",
             n_tight, n_cancel, n_noshare);
    if (error_cnt == 0 && pending_outcomes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
sv/obe_pkg.sv
sv/obe_if.sv
sv/obe_ram.sv
sv/obe_decode.sv
sv/octagon_bound_elimination.sv
tb/tb.sv
